/* hw/rtl/dtfp_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal text parser package
// Shared constants, character codes, types and the decimal weight table.
// ----------------------------------------------------------------------------
package dtfp_pkg;

   localparam int DEF_VALUE_BITS  = 48;
   localparam int DEF_FRAC_DIGITS = 4;
   localparam int DEF_COUNT_BITS  = 8;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // Nine times ten to the sixth fits in 24 bits.
   localparam int WEIGHT_BITS = 24;
   localparam int EXP_BITS    = 3;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      PH_START,
      PH_SIGNED,
      PH_INT,
      PH_FRAC
   } phase_type;

   typedef struct packed {
      logic       is_digit;
      logic       is_minus;
      logic       is_point;
      logic [3:0] digit;
   } char_class_type;

   typedef struct packed {
      logic           valid;
      char_class_type cls;
   } queue_head_type;

   function automatic logic [WEIGHT_BITS-1:0] pow10(input logic [EXP_BITS-1:0] k);
      logic [WEIGHT_BITS-1:0] r;
      case (k)
         3'd0:    r = WEIGHT_BITS'(1);
         3'd1:    r = WEIGHT_BITS'(10);
         3'd2:    r = WEIGHT_BITS'(100);
         3'd3:    r = WEIGHT_BITS'(1000);
         3'd4:    r = WEIGHT_BITS'(10000);
         3'd5:    r = WEIGHT_BITS'(100000);
         3'd6:    r = WEIGHT_BITS'(1000000);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/dtfp_front.sv */
// ----------------------------------------------------------------------------
// Decimal text parser front end
// Accepts characters, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module dtfp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_ch,
   output dtfp_pkg::queue_head_type head,
   input  logic                   pop
);
   import dtfp_pkg::*;

   localparam logic [QUEUE_PTR_BITS:0] FULL_COUNT = (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);

   char_class_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     count_ff, count_in;
   char_class_type              cls;
   logic                        push;
   logic                        do_pop;

   always_comb begin
      cls.is_digit = req_ch inside {[CHAR_ZERO:CHAR_NINE]};
      cls.is_minus = (req_ch == CHAR_MINUS);
      cls.is_point = (req_ch == CHAR_POINT);
      cls.digit    = cls.is_digit ? 4'(req_ch - CHAR_ZERO) : 4'd0;
   end

   assign req_stall  = (count_ff == FULL_COUNT);
   assign push       = req_valid && !req_stall;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cls   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* hw/rtl/dtfp_back.sv */
// ----------------------------------------------------------------------------
// Decimal text parser back end
// Runs the number state machine and the accumulator and holds the result.
// ----------------------------------------------------------------------------
module dtfp_back #(
   parameter int VALUE_BITS  = dtfp_pkg::DEF_VALUE_BITS,
   parameter int FRAC_DIGITS = dtfp_pkg::DEF_FRAC_DIGITS,
   parameter int COUNT_BITS  = dtfp_pkg::DEF_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dtfp_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [VALUE_BITS-1:0]    rsp_value,
   output logic [COUNT_BITS-1:0]    rsp_consumed,
   output logic                     rsp_error,
   output logic                     rsp_overflow
);
   import dtfp_pkg::*;

   localparam int MAG_BITS  = VALUE_BITS - 1;
   localparam int SUM_BITS  = VALUE_BITS + 4;
   localparam int FRAC_BITS = $clog2(FRAC_DIGITS + 1);
   localparam logic [SUM_BITS-1:0]  LIMIT = SUM_BITS'({MAG_BITS{1'b1}});
   localparam logic [FRAC_BITS-1:0] FRAC_MAX = FRAC_BITS'(FRAC_DIGITS);
   localparam logic [EXP_BITS-1:0]  INT_EXP = EXP_BITS'(FRAC_DIGITS);
   localparam logic [EXP_BITS-1:0]  FRAC_TOP_EXP = EXP_BITS'(FRAC_DIGITS - 1);

   phase_type               phase_ff, phase_in;
   logic                    negative_ff, negative_in;
   logic [MAG_BITS-1:0]     mag_ff, mag_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [FRAC_BITS-1:0]    frac_ff, frac_in;
   logic                    sat_ff, sat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff;
   logic [COUNT_BITS-1:0]   rsp_consumed_ff;
   logic                    rsp_error_ff;
   logic                    rsp_overflow_ff;

   char_class_type          cls;
   logic                    out_free;
   logic                    emit;
   logic                    emit_err;
   logic                    do_acc;
   logic                    by_ten;
   logic                    do_count;
   logic                    take_frac;
   logic [EXP_BITS-1:0]     exp_sel;
   logic [WEIGHT_BITS-1:0]  weight;
   logic [SUM_BITS-1:0]     wide_mag;
   logic [SUM_BITS-1:0]     sum;
   logic                    over;
   logic [COUNT_BITS-1:0]   count_inc;
   logic [VALUE_BITS-1:0]   value_pos;

   assign cls      = head.cls;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take_frac = cls.is_digit && (frac_ff < FRAC_MAX);

   always_comb begin
      emit     = 1'b0;
      emit_err = 1'b0;
      do_acc   = 1'b0;
      by_ten   = 1'b1;
      do_count = 1'b0;
      case (phase_ff)
         PH_START: begin
            if (cls.is_minus) begin
               do_count = 1'b1;
            end else if (cls.is_digit) begin
               do_acc   = 1'b1;
               do_count = 1'b1;
            end else begin
               emit     = 1'b1;
               emit_err = 1'b1;
            end
         end
         PH_SIGNED: begin
            if (cls.is_digit) begin
               do_acc   = 1'b1;
               do_count = 1'b1;
            end else begin
               emit     = 1'b1;
               emit_err = 1'b1;
            end
         end
         PH_INT: begin
            if (cls.is_digit) begin
               do_acc   = 1'b1;
               do_count = 1'b1;
            end else if (cls.is_point) begin
               do_count = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_FRAC: begin
            if (take_frac) begin
               do_acc   = 1'b1;
               by_ten   = 1'b0;
               do_count = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
            emit = 1'b1;
         end
      endcase
   end

   assign pop = head.valid && (!emit || out_free);

   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         case (phase_ff)
            PH_START: begin
               if (cls.is_minus) begin
                  phase_in = PH_SIGNED;
               end else if (cls.is_digit) begin
                  phase_in = PH_INT;
               end else begin
                  phase_in = PH_START;
               end
            end
            PH_SIGNED: phase_in = cls.is_digit ? PH_INT : PH_START;
            PH_INT: begin
               if (cls.is_digit) begin
                  phase_in = PH_INT;
               end else if (cls.is_point) begin
                  phase_in = PH_FRAC;
               end else begin
                  phase_in = PH_START;
               end
            end
            PH_FRAC: phase_in = take_frac ? PH_FRAC : PH_START;
            default: phase_in = PH_START;
         endcase
      end
   end

   always_comb begin
      exp_sel   = by_ten ? INT_EXP : FRAC_TOP_EXP - EXP_BITS'(frac_ff);
      weight    = WEIGHT_BITS'(WEIGHT_BITS'(cls.digit) * pow10(exp_sel));
      wide_mag  = SUM_BITS'(mag_ff);
      sum       = (by_ten ? (wide_mag << 3) + (wide_mag << 1) : wide_mag)
                  + SUM_BITS'(weight);
      over      = sat_ff || (sum > LIMIT);
      count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      value_pos = VALUE_BITS'(mag_ff);

      negative_in = negative_ff;
      mag_in      = mag_ff;
      count_in    = count_ff;
      frac_in     = frac_ff;
      sat_in      = sat_ff;
      if (pop) begin
         if (emit) begin
            negative_in = 1'b0;
            mag_in      = '0;
            count_in    = '0;
            frac_in     = '0;
            sat_in      = 1'b0;
         end else begin
            if (phase_ff == PH_START && cls.is_minus) begin
               negative_in = 1'b1;
            end
            if (do_acc) begin
               mag_in = over ? LIMIT[MAG_BITS-1:0] : sum[MAG_BITS-1:0];
               sat_in = over;
            end
            if (do_acc && !by_ten) begin
               frac_in = frac_ff + 1'b1;
            end
            if (do_count) begin
               count_in = count_inc;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         negative_ff  <= 1'b0;
         mag_ff       <= '0;
         count_ff     <= '0;
         frac_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         mag_ff       <= mag_in;
         count_ff     <= count_in;
         frac_ff      <= frac_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         if (emit_err) begin
            rsp_value_ff    <= '0;
            rsp_consumed_ff <= '0;
            rsp_error_ff    <= 1'b1;
            rsp_overflow_ff <= 1'b0;
         end else begin
            rsp_value_ff    <= negative_ff ? '0 - value_pos : value_pos;
            rsp_consumed_ff <= count_ff;
            rsp_error_ff    <= 1'b0;
            rsp_overflow_ff <= sat_ff;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_consumed = rsp_consumed_ff;
   assign rsp_error    = rsp_error_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

/* hw/rtl/decimal_text_to_fixed_parser_core.sv */
// ----------------------------------------------------------------------------
// Decimal text to fixed-point parser
// Parses a stream of ASCII characters into signed fixed-point numbers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_ch
// rsp       out        rsp_valid/stall    rsp_value, rsp_consumed, rsp_error,
//                                         rsp_overflow
//
// One character is taken per cycle while req_stall is low; the character that
// ends the number is queued, popped once the output is free and its result
// registered. The back end sets the rate, updating the accumulator with a
// multiply-by-ten and add per integer digit and an add per fraction digit.
// A four-entry queue separates the sides, so req_stall rises only when it fills.
// Reset is synchronous and returns the parser to the start of a number.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_parser_core #(
   parameter int VALUE_BITS  = dtfp_pkg::DEF_VALUE_BITS,
   parameter int FRAC_DIGITS = dtfp_pkg::DEF_FRAC_DIGITS,
   parameter int COUNT_BITS  = dtfp_pkg::DEF_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_ch,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_value,
   output logic [COUNT_BITS-1:0] rsp_consumed,
   output logic                  rsp_error,
   output logic                  rsp_overflow
);
   import dtfp_pkg::*;

   queue_head_type head;
   logic           pop;

   dtfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .head      (head),
      .pop       (pop)
   );

   dtfp_back #(
      .VALUE_BITS  (VALUE_BITS),
      .FRAC_DIGITS (FRAC_DIGITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_consumed (rsp_consumed),
      .rsp_error    (rsp_error),
      .rsp_overflow (rsp_overflow)
   );

   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("Back end popped an empty queue.");

   a_accept_fills_queue : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !reset) |=> head.valid)
      else $error("Accepted transaction did not reach the queue.");

   a_error_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_value == '0 && rsp_consumed == '0
                                    && !rsp_overflow))
      else $error("Error result carries a nonzero payload.");

endmodule
